[rtl/core/pfgr_pkg.sv]
// Shared types and constants for the page frame buffer glyph renderer.
`default_nettype none
package pfgr_pkg;

  localparam int SCREEN_WIDTH_DEF   = 128;
  localparam int SCREEN_HEIGHT_DEF  = 64;
  localparam int GLYPH_COUNT_DEF    = 96;
  localparam int MAX_GLYPH_ROWS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int X_W      = 7;
  localparam int Y_W      = 6;
  localparam int CODE_W   = 8;
  localparam int GROW_W   = 4;
  localparam int BITS_W   = 16;
  localparam int BIDX_W   = 10;
  localparam int FONT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_CURS  = 3'd2,
    KIND_FILL  = 3'd3,
    KIND_LOAD  = 3'd4,
    KIND_READ  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADCODE = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_FONT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_item;    // capture input item
    logic latch_sts;    // hold item status before the cursor moves
    logic clr_step;     // write one frame byte of the fill or reset clearing sweep
    logic clr_next;     // advance fill address
    logic glyph_rd;     // read glyph row for current row
    logic frame_rd;     // read frame byte for current pixel
    logic frame_wr;     // write modified frame byte
    logic pix_next;     // advance column, wrap to next row
    logic do_pixel_rd;  // read byte for single pixel
    logic do_read;      // read byte for read kind
    logic glyph_wr;     // store glyph row
    logic cursor_set;   // load cursor from item
    logic cursor_adv;   // advance cursor after character
    logic capture_rd;   // latch read data
    logic result;       // drive result
  } pfgr_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t   kind;
    logic    nofit;
    logic    badcode;
    logic    col_last;
    logic    row_last;
    logic    empty;
    logic    clr_last;
  } pfgr_sts_t;

endpackage
`default_nettype wire

[rtl/core/page_framebuffer_glyph_renderer_top.sv]
// Top level of the page frame buffer glyph renderer.
// Channel  | Handshake             | Payload
// input    | start / busy          | in_kind .. in_byte_index
// result   | out_valid (strobe)    | out_status, out_read_data, out_cursor_*
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
// After reset, busy stays high for one clearing sweep of the frame memory
// (1024 frame bytes at default size); config writes are taken.
// A character reads one glyph row per font row, then walks that row's pixels;
// each pixel is a read-modify-write on the single frame memory port.
// Clear/fill writes every frame byte in turn.
// The result strobe is registered from the done state; the receiver cannot stall.
`default_nettype none
module page_framebuffer_glyph_renderer_top #(
  parameter int SCREEN_WIDTH   = pfgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = pfgr_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_COUNT    = pfgr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = pfgr_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pfgr_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [pfgr_pkg::X_W-1:0]      in_x,
  input  wire logic [pfgr_pkg::Y_W-1:0]      in_y,
  input  wire logic                          in_pixel_on,
  input  wire logic [pfgr_pkg::CODE_W-1:0]   in_char_code,
  input  wire logic                          in_invert,
  input  wire logic [pfgr_pkg::GROW_W-1:0]   in_glyph_row_index,
  input  wire logic [pfgr_pkg::BITS_W-1:0]   in_row_bits,
  input  wire logic [pfgr_pkg::BIDX_W-1:0]   in_byte_index,
  output logic                               out_valid,
  output logic [pfgr_pkg::STATUS_W-1:0]      out_status,
  output logic [7:0]                         out_read_data,
  output logic [pfgr_pkg::X_W-1:0]           out_cursor_column,
  output logic [pfgr_pkg::Y_W-1:0]           out_cursor_row,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfgr_pkg::FONT_W-1:0]   cfg_data
);
  import pfgr_pkg::*;

  pfgr_cmd_t cmd;
  pfgr_sts_t sts;
  logic [FONT_W-1:0] font_width_r, font_height_r;
  logic              done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_width_r  <= 5'd7;
      font_height_r <= 5'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FONT_WIDTH:  font_width_r  <= cfg_data;
        REG_FONT_HEIGHT: font_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pfgr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  pfgr_datapath #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_kind),
    .in_x               (in_x),
    .in_y               (in_y),
    .in_pixel_on        (in_pixel_on),
    .in_char_code       (in_char_code),
    .in_invert          (in_invert),
    .in_glyph_row_index (in_glyph_row_index),
    .in_row_bits        (in_row_bits),
    .in_byte_index      (in_byte_index),
    .font_width         (font_width_r),
    .font_height        (font_height_r),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row)
  );

  assign out_valid = done;

endmodule
`default_nettype wire

[rtl/core/pfgr_datapath.sv]
// Datapath: frame memory, glyph memory, cursor, item registers and result.
`default_nettype none
module pfgr_datapath #(
  parameter int SCREEN_WIDTH   = pfgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = pfgr_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_COUNT    = pfgr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = pfgr_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfgr_pkg::pfgr_cmd_t           cmd,
  output pfgr_pkg::pfgr_sts_t                sts,
  input  wire logic [pfgr_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [pfgr_pkg::X_W-1:0]      in_x,
  input  wire logic [pfgr_pkg::Y_W-1:0]      in_y,
  input  wire logic                          in_pixel_on,
  input  wire logic [pfgr_pkg::CODE_W-1:0]   in_char_code,
  input  wire logic                          in_invert,
  input  wire logic [pfgr_pkg::GROW_W-1:0]   in_glyph_row_index,
  input  wire logic [pfgr_pkg::BITS_W-1:0]   in_row_bits,
  input  wire logic [pfgr_pkg::BIDX_W-1:0]   in_byte_index,
  input  wire logic [pfgr_pkg::FONT_W-1:0]   font_width,
  input  wire logic [pfgr_pkg::FONT_W-1:0]   font_height,
  output logic [pfgr_pkg::STATUS_W-1:0]      out_status,
  output logic [7:0]                         out_read_data,
  output logic [pfgr_pkg::X_W-1:0]           out_cursor_column,
  output logic [pfgr_pkg::Y_W-1:0]           out_cursor_row
);
  import pfgr_pkg::*;

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = SCREEN_WIDTH * PAGES;
  localparam int GROWS       = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int FA_W        = $clog2(FRAME_BYTES);
  localparam int GA_W        = $clog2(GROWS);
  localparam int GI_W        = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int GR_W        = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int PC_W        = 9;  // column/row sums up to 127+31

  logic [7:0]          frame_mem [FRAME_BYTES];
  logic [BITS_W-1:0]   glyph_mem [GROWS];

  logic [KIND_W-1:0]   kind_r;
  logic [X_W-1:0]      x_r;
  logic [Y_W-1:0]      y_r;
  logic                on_r, inv_r;
  logic [CODE_W-1:0]   code_r;
  logic [GROW_W-1:0]   grow_r;
  logic [BITS_W-1:0]   bits_r;
  logic [BIDX_W-1:0]   bidx_r;
  logic [X_W-1:0]      cur_col_r;
  logic [Y_W-1:0]      cur_row_r;
  logic [FONT_W-1:0]   c_r, r_r;
  logic [FA_W:0]       clr_r;
  logic [BITS_W-1:0]   pat_r;
  logic [7:0]          rd_r;
  logic [7:0]          rdata_r;
  logic                tgt_ok_r;
  logic [FA_W-1:0]     tgt_r;
  logic [2:0]          tbit_r;
  logic                tval_r;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [CODE_W-1:0]   code_off;
  logic                code_ok;
  logic [GA_W-1:0]     gaddr_load, gaddr_rd;
  logic [PC_W-1:0]     pcol, prow, chk_col, chk_row;
  logic                pbit;
  logic [PC_W-1:0]     tcol;
  logic [PC_W-1:0]     trow;
  logic                t_on;

  assign code_off = code_r - FIRST_CODE;
  assign code_ok  = (code_r >= FIRST_CODE)
                 && ({1'b0, code_r} < 9'(32 + GLYPH_COUNT));
  assign gaddr_load = GA_W'(code_off[GI_W-1:0] * MAX_GLYPH_ROWS)
                    + GA_W'(grow_r[GR_W-1:0]);
  assign gaddr_rd   = GA_W'(code_off[GI_W-1:0] * MAX_GLYPH_ROWS)
                    + GA_W'(r_r[GR_W-1:0]);

  assign chk_col = PC_W'(cur_col_r) + PC_W'(font_width);
  assign chk_row = PC_W'(cur_row_r) + PC_W'(font_height);

  // pixel currently addressed by the character walk
  assign pcol = PC_W'(cur_col_r) + PC_W'(c_r);
  assign prow = PC_W'(cur_row_r) + PC_W'(r_r);
  assign pbit = (c_r < 5'd16) ? pat_r[4'd15 - c_r[3:0]] : 1'b0;

  always_comb begin
    if (kind_r == KIND_PIXEL) begin
      tcol = PC_W'(x_r);
      trow = PC_W'(y_r);
      t_on = on_r;
    end else begin
      tcol = pcol;
      trow = prow;
      t_on = inv_r ? ~pbit : pbit;
    end
  end

  assign sts.kind     = kind_t'(kind_r);
  assign sts.nofit    = (chk_col >= PC_W'(SCREEN_WIDTH)) || (chk_row >= PC_W'(SCREEN_HEIGHT));
  assign sts.badcode  = ~code_ok;
  assign sts.col_last = (c_r == font_width - 5'd1);
  assign sts.row_last = (r_r == font_height - 5'd1);
  assign sts.empty    = (font_width == '0) || (font_height == '0);
  assign sts.clr_last = (clr_r == (FA_W+1)'(FRAME_BYTES - 1));

  // sweep address and fill value start from zero for the reset clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      on_r  <= 1'b0;
    end else if (cmd.load_item) begin
      clr_r <= '0;
      on_r  <= in_pixel_on;
    end else if (cmd.clr_next) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      x_r    <= in_x;
      y_r    <= in_y;
      code_r <= in_char_code;
      inv_r  <= in_invert;
      grow_r <= in_glyph_row_index;
      bits_r <= in_row_bits;
      bidx_r <= in_byte_index;
      c_r    <= '0;
      r_r    <= '0;
    end
    if (cmd.pix_next) begin
      if (sts.col_last) begin
        c_r <= '0;
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    // glyph rows beyond the store render off
    if (cmd.glyph_rd)
      pat_r <= ({27'd0, r_r} < 32'(MAX_GLYPH_ROWS)) ? glyph_mem[gaddr_rd] : '0;
    if (cmd.frame_rd || cmd.do_pixel_rd) begin
      tgt_ok_r <= (tcol < PC_W'(SCREEN_WIDTH)) && (trow < PC_W'(SCREEN_HEIGHT));
      tgt_r    <= FA_W'(tcol) + FA_W'((trow >> 3) * SCREEN_WIDTH);
      tbit_r   <= trow[2:0];
      tval_r   <= t_on;
      rd_r     <= frame_mem[FA_W'(tcol) + FA_W'((trow >> 3) * SCREEN_WIDTH)];
    end
    if (cmd.do_read) rd_r <= frame_mem[bidx_r[FA_W-1:0]];
    if (cmd.capture_rd)
      rdata_r <= ({22'd0, bidx_r} < 32'(FRAME_BYTES)) ? rd_r : 8'd0;
    else if (cmd.load_item)
      rdata_r <= 8'd0;
    if (cmd.latch_sts) status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) frame_mem[clr_r[FA_W-1:0]] <= {8{on_r}};
    else if (cmd.frame_wr && tgt_ok_r) begin
      frame_mem[tgt_r] <= tval_r ? (rd_r | (8'd1 << tbit_r))
                                 : (rd_r & ~(8'd1 << tbit_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.glyph_wr && code_ok && ({28'd0, grow_r} < 32'(MAX_GLYPH_ROWS)))
      glyph_mem[gaddr_load] <= bits_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else if (cmd.cursor_set) begin
      cur_col_r <= x_r;
      cur_row_r <= y_r;
    end else if (cmd.cursor_adv) begin
      cur_col_r <= cur_col_r + X_W'(font_width);
    end
  end

  // judged on the cursor before the character advances it
  always_comb begin
    status_nxt = ST_OK;
    if (kind_r == KIND_CHAR) begin
      if (sts.nofit) status_nxt = ST_NOFIT;
      else if (!code_ok) status_nxt = ST_BADCODE;
    end else if (kind_r == KIND_LOAD && !code_ok) begin
      status_nxt = ST_BADCODE;
    end
  end

  always_comb begin
    out_status        = status_r;
    out_read_data     = rdata_r;
    out_cursor_column = cur_col_r;
    out_cursor_row    = cur_row_r;
  end

endmodule
`default_nettype wire

[rtl/core/pfgr_ctrl.sv]
// Controller: sequences each item and the reset clearing sweep.
`default_nettype none
module pfgr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done,
  output pfgr_pkg::pfgr_cmd_t       cmd,
  input  wire pfgr_pkg::pfgr_sts_t  sts
);
  import pfgr_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CLR, S_GRD, S_PRD, S_PWR,
    S_PIXRD, S_PIXWR, S_BYTERD, S_BYTECAP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   init_r;
  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    done_nxt  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        cmd.clr_next = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.latch_sts = 1'b1;
        case (sts.kind)
          KIND_PIXEL: state_nxt = S_PIXRD;
          KIND_CHAR: begin
            if (sts.nofit || sts.badcode) state_nxt = S_DONE;
            else if (sts.empty) begin
              cmd.cursor_adv = 1'b1;
              state_nxt = S_DONE;
            end else state_nxt = S_GRD;
          end
          KIND_CURS: begin
            cmd.cursor_set = 1'b1;
            state_nxt = S_DONE;
          end
          KIND_FILL: state_nxt = S_CLR;
          KIND_LOAD: begin
            cmd.glyph_wr = 1'b1;
            state_nxt = S_DONE;
          end
          KIND_READ: state_nxt = S_BYTERD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.clr_next = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_GRD: begin
        cmd.glyph_rd = 1'b1;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.frame_rd = 1'b1;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.frame_wr = 1'b1;
        cmd.pix_next = 1'b1;
        if (sts.col_last) begin
          if (sts.row_last) begin
            cmd.cursor_adv = 1'b1;
            state_nxt = S_DONE;
          end else state_nxt = S_GRD;
        end else state_nxt = S_PRD;
      end
      S_PIXRD: begin
        cmd.do_pixel_rd = 1'b1;
        state_nxt = S_PIXWR;
      end
      S_PIXWR: begin
        cmd.frame_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_BYTERD: begin
        cmd.do_read = 1'b1;
        state_nxt = S_BYTECAP;
      end
      S_BYTECAP: begin
        cmd.capture_rd = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.result = 1'b1;
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= 1'b1;
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= (state_nxt == S_INIT);
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !busy_r)
    else $error("busy high in idle");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == S_DONE))
    else $error("done without result state");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");
  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    !init_r |=> !init_r)
    else $error("clearing sweep re-entered");

endmodule
`default_nettype wire

[sim/tb_page_framebuffer_glyph_renderer_top.sv]
// Self-checking testbench for the page frame buffer glyph renderer top level.
`timescale 1ns / 100ps
module tb_page_framebuffer_glyph_renderer_top;
  import pfgr_pkg::*;

  localparam int FB_BYTES   = 1024;
  localparam int GLYPHS     = 96;
  localparam int GROWS      = 16;
  localparam int ITEMS_GOAL = 850;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic              on;
    logic [CODE_W-1:0] code;
    logic              inv;
    logic [GROW_W-1:0] grow;
    logic [BITS_W-1:0] bits;
    logic [BIDX_W-1:0] bidx;
  } draw_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          rdata;
    logic [X_W-1:0]      col;
    logic [Y_W-1:0]      row;
  } draw_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  draw_cmd_t cur_cmd = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [7:0] out_read_data;
  logic [X_W-1:0] out_cursor_column;
  logic [Y_W-1:0] out_cursor_row;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FONT_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  page_framebuffer_glyph_renderer_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(cur_cmd.kind), .in_x(cur_cmd.x), .in_y(cur_cmd.y),
    .in_pixel_on(cur_cmd.on), .in_char_code(cur_cmd.code), .in_invert(cur_cmd.inv),
    .in_glyph_row_index(cur_cmd.grow), .in_row_bits(cur_cmd.bits),
    .in_byte_index(cur_cmd.bidx),
    .out_valid(out_valid), .out_status(out_status), .out_read_data(out_read_data),
    .out_cursor_column(out_cursor_column), .out_cursor_row(out_cursor_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic [7:0]  pix_mem [FB_BYTES];
  logic [15:0] font_mem [GLYPHS*GROWS];
  logic [15:0] rows_loaded [GLYPHS];
  logic [X_W-1:0] cur_col;
  logic [Y_W-1:0] cur_row;
  int unsigned fw = 7, fh = 10;

  draw_cmd_t pending_cmds[$];
  draw_rsp_t want_rsps[$];
  int unsigned idle_pct = 0;
  int errors = 0;
  int n_items = 0, n_rsps = 0, n_chars_ok = 0, n_nofit = 0, n_badcode = 0;
  int n_fills = 0, n_reads = 0;

  function automatic logic code_in_store(logic [CODE_W-1:0] code);
    return code >= FIRST_CODE && int'(code) < int'(FIRST_CODE) + GLYPHS;
  endfunction

  function automatic void plot(int c, int r, logic v);
    int idx;
    if (c >= 128 || r >= 64) return;
    idx = c + (r / 8) * 128;
    pix_mem[idx][r % 8] = v;
  endfunction

  function automatic draw_rsp_t render_step(draw_cmd_t cmd);
    draw_rsp_t rsp;
    int base;
    logic [15:0] pat;
    logic b;
    rsp = '0;
    case (cmd.kind)
      KIND_PIXEL: plot(cmd.x, cmd.y, cmd.on);
      KIND_CHAR: begin
        if (int'(cur_col) + fw >= 128 || int'(cur_row) + fh >= 64) begin
          rsp.status = ST_NOFIT;
        end else if (!code_in_store(cmd.code)) begin
          rsp.status = ST_BADCODE;
        end else begin
          base = (int'(cmd.code) - int'(FIRST_CODE)) * GROWS;
          for (int r = 0; r < fh; r++) begin
            pat = (r < GROWS) ? font_mem[base + r] : 16'h0000;
            for (int c = 0; c < fw; c++) begin
              b = (c < 16) ? pat[15 - c] : 1'b0;
              plot(cur_col + c, cur_row + r, b ^ cmd.inv);
            end
          end
          cur_col = cur_col + X_W'(fw);
        end
      end
      KIND_CURS: begin
        cur_col = cmd.x;
        cur_row = cmd.y;
      end
      KIND_FILL: foreach (pix_mem[i]) pix_mem[i] = cmd.on ? 8'hFF : 8'h00;
      KIND_LOAD: begin
        if (!code_in_store(cmd.code)) rsp.status = ST_BADCODE;
        else font_mem[(int'(cmd.code) - int'(FIRST_CODE)) * GROWS + cmd.grow] = cmd.bits;
      end
      KIND_READ: rsp.rdata = pix_mem[cmd.bidx];
      default: ;
    endcase
    rsp.col = cur_col;
    rsp.row = cur_row;
    return rsp;
  endfunction

  // predict, book-keep and queue one transaction
  task automatic issue(draw_cmd_t cmd);
    draw_rsp_t rsp;
    if (cmd.kind == KIND_LOAD && code_in_store(cmd.code))
      rows_loaded[cmd.code - FIRST_CODE][cmd.grow] = 1'b1;
    rsp = render_step(cmd);
    if (cmd.kind == KIND_CHAR) begin
      if (rsp.status == ST_OK) n_chars_ok++;
      else if (rsp.status == ST_NOFIT) n_nofit++;
      else n_badcode++;
    end
    if (cmd.kind == KIND_FILL) n_fills++;
    if (cmd.kind == KIND_READ) n_reads++;
    want_rsps.push_back(rsp);
    pending_cmds.push_back(cmd);
    n_items++;
  endtask

  function automatic draw_cmd_t noise_cmd();
    draw_cmd_t cmd;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    cmd = noise[$bits(draw_cmd_t)-1:0];
    return cmd;
  endfunction

  task automatic load_glyph(logic [CODE_W-1:0] code);
    draw_cmd_t cmd;
    for (int r = 0; r < GROWS; r++) begin
      cmd = noise_cmd();
      cmd.kind = KIND_LOAD;
      cmd.code = code;
      cmd.grow = GROW_W'(r);
      issue(cmd);
    end
  endtask

  function automatic logic glyph_ready(logic [CODE_W-1:0] code);
    int n;
    logic [15:0] need;
    n = (fh > 16) ? 16 : fh;
    need = (n == 16) ? 16'hFFFF : 16'((1 << n) - 1);
    return (rows_loaded[code - FIRST_CODE] & need) == need;
  endfunction

  task automatic random_cmd();
    draw_cmd_t cmd;
    int unsigned pick;
    int tries;
    cmd = noise_cmd();
    pick = $urandom_range(99);
    if (pick < 4) begin
      load_glyph(CODE_W'(FIRST_CODE + $urandom_range(GLYPHS - 1)));
      return;
    end else if (pick < 14) begin
      cmd.kind = KIND_LOAD;
    end else if (pick < 42) begin
      cmd.kind = KIND_CHAR;
      if ($urandom_range(9) != 0) cmd.code = CODE_W'(FIRST_CODE + $urandom_range(GLYPHS - 1));
      // keep renders on loaded glyph rows; the fit check comes first
      if (int'(cur_col) + fw < 128 && int'(cur_row) + fh < 64 && code_in_store(cmd.code)) begin
        tries = 0;
        while (!glyph_ready(cmd.code) && tries < 200) begin
          cmd.code = CODE_W'(FIRST_CODE + $urandom_range(GLYPHS - 1));
          tries++;
        end
        if (!glyph_ready(cmd.code)) cmd.code = CODE_W'($urandom_range(31));
      end
    end else if (pick < 56) begin
      cmd.kind = KIND_CURS;
      if ($urandom_range(4) != 0 && fw < 127 && fh < 63) begin
        cmd.x = X_W'($urandom_range(127 - fw));
        cmd.y = Y_W'($urandom_range(63 - fh));
        if (int'(cmd.x) + fw >= 128) cmd.x = '0;
        if (int'(cmd.y) + fh >= 64) cmd.y = '0;
      end
    end else if (pick < 72) begin
      cmd.kind = KIND_PIXEL;
    end else if (pick < 94) begin
      cmd.kind = KIND_READ;
    end else if (pick < 96) begin
      cmd.kind = KIND_FILL;
    end else begin
      cmd.kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    end
    issue(cmd);
  endtask

  function automatic draw_cmd_t mk(logic [KIND_W-1:0] kind, int x, int y, logic on,
                                   int code, int grow, int bits, int bidx);
    draw_cmd_t cmd;
    cmd = noise_cmd();
    cmd.kind = kind;
    cmd.x = X_W'(x);
    cmd.y = Y_W'(y);
    cmd.on = on;
    cmd.code = CODE_W'(code);
    cmd.inv = 1'($urandom_range(1));
    cmd.grow = GROW_W'(grow);
    cmd.bits = BITS_W'(bits);
    cmd.bidx = BIDX_W'(bidx);
    return cmd;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || want_rsps.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= FONT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FONT_WIDTH) fw = val;
    else fh = val;
  endtask

  // driver: hold the item until start && !busy takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_cmd <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    draw_rsp_t want;
    if (rst_n && out_valid) begin
      if (want_rsps.size() == 0) begin
        $display("MISMATCH at %0t: result with nothing outstanding", $realtime);
        errors++;
      end else begin
        want = want_rsps.pop_front();
        n_rsps++;
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_read_data !== want.rdata) report_mismatch("read_data", out_read_data, want.rdata);
        if (out_cursor_column !== want.col)
          report_mismatch("cursor_column", out_cursor_column, want.col);
        if (out_cursor_row !== want.row) report_mismatch("cursor_row", out_cursor_row, want.row);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding", want_rsps.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned widths [6]  = '{7, 16, 1, 0, 16, 5};
    int unsigned heights [6] = '{10, 16, 1, 0, 1, 16};
    int unsigned idles [6]   = '{0, 86, 0, 31, 86, 0};
    int per_phase;
    int stop;
    foreach (pix_mem[i]) pix_mem[i] = 8'h00;
    foreach (font_mem[i]) font_mem[i] = 16'h0000;
    foreach (rows_loaded[i]) rows_loaded[i] = 16'h0000;
    cur_col = '0;
    cur_row = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every kind, refusals
    issue(mk(KIND_PIXEL, 0, 0, 1, 0, 0, 0, 0));
    issue(mk(KIND_PIXEL, 127, 63, 1, 0, 0, 0, 0));
    issue(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 1023));
    issue(mk(KIND_PIXEL, 127, 63, 0, 0, 0, 0, 0));
    issue(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 1023));
    issue(mk(KIND_FILL, 0, 0, 1, 0, 0, 0, 0));
    issue(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 500));
    issue(mk(KIND_FILL, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_LOAD, 0, 0, 0, 31, 3, 16'hFFFF, 0));
    issue(mk(KIND_LOAD, 0, 0, 0, 128, 15, 16'hA5A5, 0));
    issue(mk(KIND_LOAD, 0, 0, 0, 255, 0, 16'h0000, 0));
    issue(mk(KIND_CHAR, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_CHAR, 0, 0, 0, 200, 0, 0, 0));
    issue(mk(KIND_CURS, 127, 63, 0, 0, 0, 0, 0));
    issue(mk(KIND_CHAR, 0, 0, 0, 65, 0, 0, 0));
    issue(mk(KIND_SPARE6, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_SPARE7, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_CURS, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(KIND_LOAD, 0, 0, 0, 32, 15, 16'hFFFF, 0));
    issue(mk(KIND_LOAD, 0, 0, 0, 127, 0, 16'h0000, 0));
    drain();

    per_phase = ITEMS_GOAL / 6;
    foreach (widths[p]) begin
      write_reg(REG_FONT_WIDTH, widths[p]);
      write_reg(REG_FONT_HEIGHT, heights[p]);
      idle_pct = idles[p];
      stop = n_items + per_phase;
      // seed every phase with two complete glyphs so renders go deep
      load_glyph(CODE_W'(FIRST_CODE + $urandom_range(GLYPHS - 1)));
      load_glyph(CODE_W'(FIRST_CODE + 95));
      while (n_items < stop) random_cmd();
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Ran %0d transactions, %0d results checked, %0d reads, %0d clear/fill",
             n_items, n_rsps, n_reads, n_fills);
    $display("Characters: %0d drawn, %0d refused off edge, %0d bad code; 6 font settings",
             n_chars_ok, n_nofit, n_badcode);
    if (errors == 0 && want_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
